>>> rtl/aodv_rt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aodv_rt_pkg
// Shared types, codes and sizes of the AODV route table unit.
// ----------------------------------------------------------------------------
package aodv_rt_pkg;

    // Table size; only destinations 0..31 can be addressed by the 5-bit ID
    localparam int NODES   = 32;
    localparam int TABLE_N = (NODES < 32) ? NODES : 32;
    localparam int IDX_W   = (TABLE_N > 1) ? $clog2(TABLE_N) : 1;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 120;

    // Route states
    localparam logic [1:0] ST_UNDEF   = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef enum logic [2:0] {
        OP_UPDATE     = 3'd0,
        OP_SET_STATE  = 3'd1,
        OP_LOOKUP     = 3'd2,
        OP_ADD_PREC   = 3'd3,
        OP_DEL_PREC   = 3'd4,
        OP_LINK_BREAK = 3'd5,
        OP_FWD_BREAK  = 3'd6,
        OP_RAISE_SEQ  = 3'd7
    } op_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SINGLE,
        FSM_SCAN,
        FSM_SCAN_DONE
    } fsm_t;

    // Request item, last field in the lowest bits
    typedef struct packed {
        logic [4:0]  precursor_node;
        logic [31:0] node_mask;
        logic [4:0]  next_hop;
        logic [7:0]  hops;
        logic [1:0]  route_state;
        logic        dest_seq_valid;
        logic [31:0] seq;
        logic [4:0]  dest;
        op_t         op;
    } req_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [31:0] affected_dests;
        logic [31:0] out_precursors;
        logic [7:0]  out_hops;
        logic [1:0]  out_state;
        logic        out_seq_valid;
        logic [31:0] out_seq;
        logic [4:0]  out_next_hop;
        logic        route_valid;
        logic        found;
    } rsp_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0] precursors;
        logic [4:0]  next_hop;
        logic [7:0]  hops;
        logic [1:0]  state;
        logic        seq_valid;
        logic [31:0] seq;
    } entry_t;

    localparam int REQ_W = $bits(req_t);
    localparam int RSP_W = $bits(rsp_t);

endpackage

>>> rtl/aodv_rt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aodv_rt_ram
// Entry RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aodv_rt_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [aodv_rt_pkg::IDX_W-1:0] wr_addr,
    input  aodv_rt_pkg::entry_t       wr_data,
    input  logic                      rd_en,
    input  logic [aodv_rt_pkg::IDX_W-1:0] rd_addr,
    output aodv_rt_pkg::entry_t       rd_data
);

    aodv_rt_pkg::entry_t mem [aodv_rt_pkg::TABLE_N];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/aodv_route_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aodv_route_table_unit
// Direct-mapped AODV route table: update, lookup, precursor edits and
// broken-link scans over an entry RAM with a read-modify-write controller.
// ----------------------------------------------------------------------------
//  Channel  | Ports                       | Item
//  ---------+-----------------------------+-----------------------------------
//  request  | s_tvalid s_tready s_tdata   | one table operation (96-bit data)
//  result   | m_tvalid m_tready m_tdata   | one result per request (120 bits)
//
//  Single-entry operations issue the RAM read at accept, then modify,
//  write back and load the result register. Link-broken and
//  forward-broken scan the whole table, reading one entry per cycle
//  through the single RAM read port.
//  Reset clears the present bits in flip-flops at once; no clearing pass.
//  A stalled result holds the controller in its last state; a new request
//  is accepted while a finished result still waits in the output register.
// ----------------------------------------------------------------------------
module aodv_route_table_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[2:0] dest[7:3] seq[39:8] dest_seq_valid[40] route_state[42:41]
    // hops[50:43] next_hop[55:51] node_mask[87:56] precursor_node[92:88]
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found[0] route_valid[1] out_next_hop[6:2] out_seq[38:7]
    // out_seq_valid[39] out_state[41:40] out_hops[49:42]
    // out_precursors[81:50] affected_dests[113:82]
    output logic [119:0] m_tdata
);

    localparam logic [aodv_rt_pkg::IDX_W-1:0] LAST_IDX =
        aodv_rt_pkg::IDX_W'(aodv_rt_pkg::TABLE_N - 1);

    aodv_rt_pkg::fsm_t state_reg, state_next;
    aodv_rt_pkg::req_t req_reg, req_next, s_req;
    aodv_rt_pkg::rsp_t rsp_reg, rsp_next, single_rsp;
    logic [aodv_rt_pkg::TABLE_N-1:0] present_reg, present_next;
    logic [aodv_rt_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [31:0] dmask_reg, dmask_next, pmask_reg, pmask_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic                          s_acc, out_free;
    logic                          wr_en, rd_en;
    logic [aodv_rt_pkg::IDX_W-1:0] wr_addr, rd_addr, d_idx;
    aodv_rt_pkg::entry_t           wr_data, rd_entry, new_entry;
    logic                          in_table, here, fresher, keep, hit;

    assign s_req    = aodv_rt_pkg::req_t'(s_tdata[aodv_rt_pkg::REQ_W-1:0]);
    assign s_tready = (state_reg == aodv_rt_pkg::FSM_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(aodv_rt_pkg::M_TDATA_W - aodv_rt_pkg::RSP_W)'(0), rsp_reg};

    aodv_rt_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Modify one addressed entry (all operations but the link scans)
    always_comb begin
        d_idx    = req_reg.dest[aodv_rt_pkg::IDX_W-1:0];
        in_table = ({1'b0, req_reg.dest} < 6'(aodv_rt_pkg::TABLE_N));
        here     = in_table && present_reg[d_idx];
        fresher  = (rd_entry.state != aodv_rt_pkg::ST_VALID) ||
                   (rd_entry.seq < req_reg.seq) ||
                   ((rd_entry.seq == req_reg.seq) && (rd_entry.hops > req_reg.hops));
        new_entry = rd_entry;
        keep      = here;
        case (req_reg.op)
            aodv_rt_pkg::OP_UPDATE: begin
                if (in_table && !here) begin
                    new_entry.seq        = req_reg.seq;
                    new_entry.seq_valid  = req_reg.dest_seq_valid;
                    new_entry.state      = req_reg.route_state;
                    new_entry.hops       = req_reg.hops;
                    new_entry.next_hop   = req_reg.next_hop;
                    new_entry.precursors = req_reg.node_mask;
                    keep                 = 1'b1;
                end else if (here && fresher) begin
                    new_entry.seq        = req_reg.seq;
                    new_entry.seq_valid  = req_reg.dest_seq_valid;
                    new_entry.state      = req_reg.route_state;
                    new_entry.hops       = req_reg.hops;
                    new_entry.next_hop   = req_reg.next_hop;
                    new_entry.precursors = rd_entry.precursors | req_reg.node_mask;
                end
            end
            aodv_rt_pkg::OP_SET_STATE: begin
                new_entry.state = req_reg.route_state;
            end
            aodv_rt_pkg::OP_ADD_PREC: begin
                new_entry.precursors = rd_entry.precursors |
                                       (32'd1 << req_reg.precursor_node);
            end
            aodv_rt_pkg::OP_DEL_PREC: begin
                new_entry.precursors = rd_entry.precursors &
                                       ~(32'd1 << req_reg.precursor_node);
            end
            aodv_rt_pkg::OP_RAISE_SEQ: begin
                if (rd_entry.seq < req_reg.seq) begin
                    new_entry.seq = req_reg.seq;
                end
            end
            default: begin
            end
        endcase

        single_rsp = '0;
        if (keep) begin
            single_rsp.found          = 1'b1;
            single_rsp.route_valid    = (new_entry.state == aodv_rt_pkg::ST_VALID);
            single_rsp.out_next_hop   = new_entry.next_hop;
            single_rsp.out_seq        = new_entry.seq;
            single_rsp.out_seq_valid  = new_entry.seq_valid;
            single_rsp.out_state      = new_entry.state;
            single_rsp.out_hops       = new_entry.hops;
            single_rsp.out_precursors = new_entry.precursors;
        end
    end

    // Scan hit: present valid route through the given neighbor, masked in for a forward break
    assign hit = present_reg[idx_reg] &&
                 (rd_entry.state == aodv_rt_pkg::ST_VALID) &&
                 (rd_entry.next_hop == req_reg.next_hop) &&
                 ((req_reg.op == aodv_rt_pkg::OP_LINK_BREAK) ||
                  req_reg.node_mask[idx_reg]);

    // Next state and datapath control
    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        present_next  = present_reg;
        idx_next      = idx_reg;
        dmask_next    = dmask_reg;
        pmask_next    = pmask_reg;
        m_tvalid_next = m_tvalid_reg;
        wr_en         = 1'b0;
        wr_addr       = d_idx;
        wr_data       = new_entry;
        rd_en         = 1'b0;
        rd_addr       = s_req.dest[aodv_rt_pkg::IDX_W-1:0];

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            aodv_rt_pkg::FSM_IDLE: begin
                if (s_acc) begin
                    req_next   = s_req;
                    rd_en      = 1'b1;
                    idx_next   = '0;
                    dmask_next = '0;
                    pmask_next = '0;
                    if ((s_req.op == aodv_rt_pkg::OP_LINK_BREAK) ||
                        (s_req.op == aodv_rt_pkg::OP_FWD_BREAK)) begin
                        rd_addr    = '0;
                        state_next = aodv_rt_pkg::FSM_SCAN;
                    end else begin
                        state_next = aodv_rt_pkg::FSM_SINGLE;
                    end
                end
            end
            aodv_rt_pkg::FSM_SINGLE: begin
                // Write back and publish together, only when the output is free
                if (out_free) begin
                    wr_en         = keep;
                    if (keep) begin
                        present_next[d_idx] = 1'b1;
                    end
                    rsp_next      = single_rsp;
                    m_tvalid_next = 1'b1;
                    state_next    = aodv_rt_pkg::FSM_IDLE;
                end
            end
            aodv_rt_pkg::FSM_SCAN: begin
                wr_addr         = idx_reg;
                wr_data         = rd_entry;
                wr_data.state   = aodv_rt_pkg::ST_INVALID;
                if (req_reg.op == aodv_rt_pkg::OP_LINK_BREAK) begin
                    wr_data.seq = rd_entry.seq + 32'd1;
                end
                if (hit) begin
                    wr_en      = 1'b1;
                    dmask_next = dmask_reg | (32'd1 << idx_reg);
                    pmask_next = pmask_reg | rd_entry.precursors;
                end
                // Advance to the next entry
                if (idx_reg == LAST_IDX) begin
                    state_next = aodv_rt_pkg::FSM_SCAN_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            aodv_rt_pkg::FSM_SCAN_DONE: begin
                if (out_free) begin
                    rsp_next                = '0;
                    rsp_next.out_precursors = pmask_reg;
                    rsp_next.affected_dests = dmask_reg;
                    m_tvalid_next           = 1'b1;
                    state_next              = aodv_rt_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = aodv_rt_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= aodv_rt_pkg::FSM_IDLE;
            present_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            present_reg  <= present_next;
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        dmask_reg <= dmask_next;
        pmask_reg <= pmask_next;
    end

    // A link request starts its scan at entry zero
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && ((s_req.op == aodv_rt_pkg::OP_LINK_BREAK) ||
                   (s_req.op == aodv_rt_pkg::OP_FWD_BREAK)))
        |=> (state_reg == aodv_rt_pkg::FSM_SCAN) && (idx_reg == '0))
        else $error("link scan did not start at entry zero");

    // The scan steps through entries one per cycle
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == aodv_rt_pkg::FSM_SCAN) && (idx_reg != LAST_IDX))
        |=> (state_reg == aodv_rt_pkg::FSM_SCAN) &&
            (idx_reg == $past(idx_reg) + 1'b1))
        else $error("scan index skipped or stalled");

    // Single-entry results never report affected destinations
    a_single_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == aodv_rt_pkg::FSM_SINGLE) && out_free)
        |=> m_tvalid_reg && (rsp_reg.affected_dests == '0))
        else $error("single-entry result carries an affected mask");

    // A valid route is always a found entry
    a_valid_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && rsp_reg.route_valid) |-> rsp_reg.found)
        else $error("route_valid without found");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the AODV route table unit. A route table model
// tracks every entry and predicts one result per accepted request; the
// results coming back are compared field by field in order. A directed
// opening covers the edge cases. Random traffic follows, mostly on a few
// next hops so that broken-link scans hit live routes. Requests arrive in
// bursts with gaps, and the result side stalls in changing patterns.
// ----------------------------------------------------------------------------
import aodv_rt_pkg::*;

// Route table model and the queue of results it expects
class route_table_model;
    bit     present[TABLE_N];
    entry_t entries[TABLE_N];
    rsp_t   expected_results[$];
    int     faults;
    int     results_seen;

    function new();
        foreach (present[i]) present[i] = 1'b0;
        faults = 0;
        results_seen = 0;
    endfunction

    // Apply one accepted request to the table and queue its result
    function void note_request(req_t r);
        rsp_t e;
        int   i;
        e = '0;
        if (r.op == OP_LINK_BREAK || r.op == OP_FWD_BREAK) begin
            // Invalidate live routes through the broken neighbor
            for (i = 0; i < TABLE_N; i++) begin
                if ((r.op == OP_LINK_BREAK || r.node_mask[i]) && present[i] &&
                    entries[i].state == ST_VALID &&
                    entries[i].next_hop == r.next_hop) begin
                    entries[i].state = ST_INVALID;
                    if (r.op == OP_LINK_BREAK)
                        entries[i].seq = entries[i].seq + 32'd1;
                    e.out_precursors = e.out_precursors | entries[i].precursors;
                    e.affected_dests[i] = 1'b1;
                end
            end
        end else begin
            case (r.op)
                OP_UPDATE: begin
                    if (!present[r.dest]) begin
                        present[r.dest] = 1'b1;
                        entries[r.dest].precursors = r.node_mask;
                        entries[r.dest].next_hop   = r.next_hop;
                        entries[r.dest].hops       = r.hops;
                        entries[r.dest].state      = r.route_state;
                        entries[r.dest].seq_valid  = r.dest_seq_valid;
                        entries[r.dest].seq        = r.seq;
                    end else if (entries[r.dest].state != ST_VALID ||
                                 entries[r.dest].seq < r.seq ||
                                 (entries[r.dest].seq == r.seq &&
                                  entries[r.dest].hops > r.hops)) begin
                        // Fresher or shorter route: replace, merge precursors
                        entries[r.dest].precursors =
                            entries[r.dest].precursors | r.node_mask;
                        entries[r.dest].next_hop  = r.next_hop;
                        entries[r.dest].hops      = r.hops;
                        entries[r.dest].state     = r.route_state;
                        entries[r.dest].seq_valid = r.dest_seq_valid;
                        entries[r.dest].seq       = r.seq;
                    end
                end
                OP_SET_STATE: begin
                    if (present[r.dest]) entries[r.dest].state = r.route_state;
                end
                OP_ADD_PREC: begin
                    if (present[r.dest])
                        entries[r.dest].precursors[r.precursor_node] = 1'b1;
                end
                OP_DEL_PREC: begin
                    if (present[r.dest])
                        entries[r.dest].precursors[r.precursor_node] = 1'b0;
                end
                OP_RAISE_SEQ: begin
                    if (present[r.dest] && entries[r.dest].seq < r.seq)
                        entries[r.dest].seq = r.seq;
                end
                default: ;
            endcase
            // Report the entry as it stands after the operation
            if (present[r.dest]) begin
                e.found          = 1'b1;
                e.route_valid    = (entries[r.dest].state == ST_VALID);
                e.out_next_hop   = entries[r.dest].next_hop;
                e.out_seq        = entries[r.dest].seq;
                e.out_seq_valid  = entries[r.dest].seq_valid;
                e.out_state      = entries[r.dest].state;
                e.out_hops       = entries[r.dest].hops;
                e.out_precursors = entries[r.dest].precursors;
            end
        end
        expected_results = {expected_results, e};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            faults++;
            if (faults <= 10)
                $display("result %0d: %s mismatch, expected %h, got %h",
                         results_seen, name, want, got);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(rsp_t got);
        rsp_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("result %0d: item arrived with none expected", results_seen);
            return;
        end
        want = expected_results.pop_front();
        compare_field("found", 32'(want.found), 32'(got.found));
        compare_field("route_valid", 32'(want.route_valid), 32'(got.route_valid));
        compare_field("out_next_hop", 32'(want.out_next_hop), 32'(got.out_next_hop));
        compare_field("out_seq", want.out_seq, got.out_seq);
        compare_field("out_seq_valid", 32'(want.out_seq_valid), 32'(got.out_seq_valid));
        compare_field("out_state", 32'(want.out_state), 32'(got.out_state));
        compare_field("out_hops", 32'(want.out_hops), 32'(got.out_hops));
        compare_field("out_precursors", want.out_precursors, got.out_precursors);
        compare_field("affected_dests", want.affected_dests, got.affected_dests);
    endfunction
endclass

module testbench;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } rx_mode_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    bit           s_accept = 1'b0;
    rx_mode_t     rx_mode = RX_OPEN;
    int           rx_mode_left = 0;
    int           rx_stall_left = 0;

    route_table_model table_model;

    aodv_route_table_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sample both channels mid-cycle; the handshake completes at the next edge
    always @(negedge aclk) begin
        s_accept = aresetn && s_tvalid && s_tready;
        if (s_accept)
            table_model.note_request(req_t'(s_tdata[REQ_W-1:0]));
        if (aresetn && m_tvalid && m_tready)
            table_model.check_result(rsp_t'(m_tdata[RSP_W-1:0]));
    end

    // Stall the result side in patterns that switch at random
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_t'($urandom_range(3));
            rx_mode_left <= int'($urandom_range(64, 256));
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(1));
            RX_SPARSE: m_tready <= ($urandom_range(3) == 0);
            default: begin
                if (rx_stall_left != 0) begin
                    m_tready      <= 1'b0;
                    rx_stall_left <= rx_stall_left - 1;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(7) == 0)
                        rx_stall_left <= int'($urandom_range(4, 16));
                end
            end
        endcase
    end

    function automatic req_t make_request(op_t op, logic [4:0] dest, logic [31:0] seq,
                                          logic sv, logic [1:0] st, logic [7:0] hops,
                                          logic [4:0] nh, logic [31:0] mask,
                                          logic [4:0] pre);
        req_t r;
        r.op             = op;
        r.dest           = dest;
        r.seq            = seq;
        r.dest_seq_valid = sv;
        r.route_state    = st;
        r.hops           = hops;
        r.next_hop       = nh;
        r.node_mask      = mask;
        r.precursor_node = pre;
        return r;
    endfunction

    // Random request, mostly aimed at a few next hops and small sequence numbers
    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)      r.op = OP_UPDATE;
        else if (pick < 40) r.op = OP_LOOKUP;
        else if (pick < 48) r.op = OP_SET_STATE;
        else if (pick < 56) r.op = OP_ADD_PREC;
        else if (pick < 64) r.op = OP_DEL_PREC;
        else if (pick < 72) r.op = OP_LINK_BREAK;
        else if (pick < 82) r.op = OP_FWD_BREAK;
        else                r.op = OP_RAISE_SEQ;
        r.dest = 5'($urandom_range(31));
        case ($urandom_range(9))
            0:       r.seq = $urandom;
            1:       r.seq = 32'hFFFF_FFFF - 32'($urandom_range(3));
            default: r.seq = 32'($urandom_range(15));
        endcase
        r.dest_seq_valid = 1'($urandom_range(1));
        r.route_state = ($urandom_range(9) < 6) ? ST_VALID : 2'($urandom_range(3));
        r.hops = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                          : 8'($urandom_range(7));
        r.next_hop = ($urandom_range(4) == 0) ? 5'($urandom_range(31))
                                              : 5'($urandom_range(3));
        r.node_mask = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom;
        r.precursor_node = 5'($urandom_range(31));
        return r;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_request(input req_t r);
        s_tdata  <= {{(S_TDATA_W-REQ_W){1'b0}}, r};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_accept);
    endtask

    task automatic run_directed();
        // Operations on an absent entry and a scan of an empty table
        send_request(make_request(OP_LOOKUP, 5, 0, 0, ST_UNDEF, 0, 0, 0, 0));
        send_request(make_request(OP_SET_STATE, 5, 0, 0, ST_VALID, 0, 0, 0, 0));
        send_request(make_request(OP_ADD_PREC, 5, 0, 0, ST_UNDEF, 0, 0, 0, 3));
        send_request(make_request(OP_DEL_PREC, 5, 0, 0, ST_UNDEF, 0, 0, 0, 3));
        send_request(make_request(OP_RAISE_SEQ, 5, 32'hFFFF_FFFF, 0, ST_UNDEF, 0, 0, 0, 0));
        send_request(make_request(OP_LINK_BREAK, 0, 0, 0, ST_UNDEF, 0, 0, 0, 0));
        // Inserts at the field extremes
        send_request(make_request(OP_UPDATE, 0, 32'hFFFF_FFFF, 1, ST_VALID, 255, 31,
                                  32'hFFFF_FFFF, 31));
        send_request(make_request(OP_UPDATE, 31, 0, 0, ST_VALID, 0, 0, 0, 0));
        // Equal sequence, same hops: keep
        send_request(make_request(OP_UPDATE, 31, 0, 1, ST_VALID, 0, 5, 1, 0));
        // Equal sequence, fewer hops: replace
        send_request(make_request(OP_UPDATE, 0, 32'hFFFF_FFFF, 0, ST_VALID, 254, 31, 0, 0));
        // Stale sequence: keep
        send_request(make_request(OP_UPDATE, 0, 5, 1, ST_VALID, 1, 4, 32'h10, 0));
        send_request(make_request(OP_UPDATE, 7, 100, 1, ST_VALID, 3, 31, 32'h80, 0));
        send_request(make_request(OP_LOOKUP, 7, 0, 0, ST_UNDEF, 0, 0, 0, 0));
        // Precursor add, duplicate add, remove
        send_request(make_request(OP_ADD_PREC, 7, 0, 0, ST_UNDEF, 0, 0, 0, 31));
        send_request(make_request(OP_ADD_PREC, 7, 0, 0, ST_UNDEF, 0, 0, 0, 31));
        send_request(make_request(OP_DEL_PREC, 7, 0, 0, ST_UNDEF, 0, 0, 0, 7));
        // Raise with an older then a newer number
        send_request(make_request(OP_RAISE_SEQ, 7, 50, 0, ST_UNDEF, 0, 0, 0, 0));
        send_request(make_request(OP_RAISE_SEQ, 7, 200, 0, ST_UNDEF, 0, 0, 0, 0));
        // Reserved state counts as not valid, so an older update replaces it
        send_request(make_request(OP_SET_STATE, 7, 0, 0, 2'd3, 0, 0, 0, 0));
        send_request(make_request(OP_UPDATE, 7, 1, 1, ST_VALID, 9, 31, 32'h2, 0));
        // Link break through node 31 wraps the all-ones sequence number
        send_request(make_request(OP_LINK_BREAK, 0, 0, 0, ST_UNDEF, 0, 31, 0, 0));
        send_request(make_request(OP_UPDATE, 0, 0, 1, ST_VALID, 255, 2, 0, 0));
        // Forward break with destination 0 masked out, then destination 31 masked in
        send_request(make_request(OP_FWD_BREAK, 0, 0, 0, ST_UNDEF, 0, 2,
                                  32'hFFFF_FFFE, 0));
        send_request(make_request(OP_FWD_BREAK, 0, 0, 0, ST_UNDEF, 0, 0,
                                  32'h8000_0000, 0));
        send_request(make_request(OP_LOOKUP, 31, 0, 0, ST_UNDEF, 0, 0, 0, 0));
    endtask

    // Random traffic in bursts with gaps of random length
    task automatic run_random();
        int sent;
        int burst;
        sent = 0;
        while (sent < 1800) begin
            burst = int'($urandom_range(1, 12));
            repeat (burst) begin
                send_request(random_request());
                sent++;
            end
            if ($urandom_range(3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        table_model = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        // Drain outstanding results, then allow one scan's worth of slack
        while (table_model.expected_results.size() != 0) @(posedge aclk);
        repeat (TABLE_N + 8) @(posedge aclk);
        if (table_model.faults == 0 && table_model.expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
